// ===== src/assert_macros.svh =====
// Assertion helpers for the checker file.
// Every assertion is clocked on the rising edge and is idle while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside of reset.
`define SBS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be true at a clock edge outside of reset.
`define SBS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `SBS_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== src/sbs_pkg.sv =====
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared sizes and codes for the sorted-table binary search block.
// ----------------------------------------------------------------------------
package sbs_pkg;

  // Table geometry and key size.
  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_WIDTH   = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  // Widths fixed by the interface fields.
  localparam int POS_W    = 11;
  localparam int IN_KEY_W = 32;

  // Operation codes carried on the operation port.
  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

endpackage

// ===== src/sbs_ram.sv =====
// ----------------------------------------------------------------------------
// sbs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/sorted_table_binary_search_top.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top
// Key table with a halving search over positions 1 to the configured length.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on start_i while busy_o is low. A write command stores
//   entry_key_i at entry_position_i (positions 1 to TABLE_DEPTH; others are
//   dropped) and gives no result. A search command looks for search_key_i
//   in positions 1 to table_length and gives one result.
//   The result appears on found_o and match_position_o for one cycle, marked
//   by valid_o; match_position_o is 0 when the key is not found. The receiver
//   must take it in that cycle.
//   Timing: a search probes one table entry per cycle while busy_o is high,
//   and the result follows on the cycle after the last probe. The loop
//   through the RAM read port and the key comparator sets the probe rate.
//   A search on an empty table reports in the cycle after the transfer.
//   The block is idle while the result is shown, so the next command may
//   enter in that cycle.
//   Configuration: cfg_we_i loads table_length from cfg_wdata_i; lengths
//   above TABLE_DEPTH count as TABLE_DEPTH.
//   Reset clears table_length and the sequencer; table contents are kept.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top
  import sbs_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       operation_i,
  input  logic [POS_W-1:0]           entry_position_i,
  input  logic signed [IN_KEY_W-1:0] entry_key_i,
  input  logic signed [IN_KEY_W-1:0] search_key_i,
  input  logic                       cfg_we_i,
  input  logic [POS_W-1:0]           cfg_wdata_i,
  output logic                       valid_o,
  output logic                       found_o,
  output logic [POS_W-1:0]           match_position_o
);

  typedef enum logic {
    S_IDLE,
    S_PROBE
  } state_e;

  localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(TABLE_DEPTH);
  localparam logic [POS_W-1:0] ONE_POS   = POS_W'(1);

  state_e                      state_q, state_d;
  logic [POS_W-1:0]            len_q;
  logic [POS_W-1:0]            left_q, left_d;
  logic [POS_W-1:0]            right_q, right_d;
  logic [POS_W-1:0]            mid_q, mid_d;
  logic signed [KEY_WIDTH-1:0] key_q, key_d;
  logic                        valid_q, valid_d;
  logic                        found_q, found_d;
  logic [POS_W-1:0]            pos_q, pos_d;

  logic                        accept;
  logic [POS_W-1:0]            len_clamp;
  logic [POS_W:0]              sum_init;
  logic [POS_W-1:0]            mid_init;
  logic signed [KEY_WIDTH-1:0] probe_key;
  logic                        key_lt;
  logic                        key_eq;
  logic [POS_W-1:0]            left_n;
  logic [POS_W-1:0]            right_n;
  logic [POS_W:0]              sum_n;
  logic [POS_W-1:0]            mid_n;
  logic                        crossed;
  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_waddr;
  logic [KEY_WIDTH-1:0]        ram_wdata;
  logic [ADDR_W-1:0]           ram_raddr;
  logic [KEY_WIDTH-1:0]        ram_rdata;

  assign accept = start_i && (state_q == S_IDLE);

  // Effective length and the first midpoint of a new search.
  assign len_clamp = (len_q > DEPTH_POS) ? DEPTH_POS : len_q;
  assign sum_init  = {1'b0, ONE_POS} + {1'b0, len_clamp};
  assign mid_init  = sum_init[POS_W:1];

  // One probe step: compare against the entry at mid and narrow the bounds.
  assign probe_key = signed'(ram_rdata);
  assign key_lt    = key_q < probe_key;
  assign key_eq    = key_q == probe_key;
  assign left_n    = key_lt ? left_q : mid_q + ONE_POS;
  assign right_n   = key_lt ? mid_q - ONE_POS : right_q;
  assign crossed   = left_n > right_n;
  assign sum_n     = {1'b0, left_n} + {1'b0, right_n};
  assign mid_n     = sum_n[POS_W:1];

  // Table write port, used only by write commands with a valid position.
  assign ram_we    = accept && (operation_i == OP_WRITE) &&
                     (entry_position_i != '0) && (entry_position_i <= DEPTH_POS);
  assign ram_waddr = ADDR_W'(entry_position_i - ONE_POS);
  assign ram_wdata = KEY_WIDTH'(entry_key_i);

  // Read address: the first midpoint when idle, the next midpoint while probing.
  always_comb begin
    if (state_q == S_IDLE) begin
      ram_raddr = ADDR_W'(mid_init - ONE_POS);
    end else begin
      ram_raddr = ADDR_W'(mid_n - ONE_POS);
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    left_d  = left_q;
    right_d = right_q;
    mid_d   = mid_q;
    key_d   = key_q;
    valid_d = 1'b0;
    found_d = found_q;
    pos_d   = pos_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (operation_i == OP_SEARCH)) begin
          key_d   = KEY_WIDTH'(search_key_i);
          left_d  = ONE_POS;
          right_d = len_clamp;
          mid_d   = mid_init;
          if (len_clamp == '0) begin
            valid_d = 1'b1;
            found_d = 1'b0;
            pos_d   = '0;
          end else begin
            state_d = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (key_eq) begin
          state_d = S_IDLE;
          valid_d = 1'b1;
          found_d = 1'b1;
          pos_d   = mid_q;
        end else if (crossed) begin
          state_d = S_IDLE;
          valid_d = 1'b1;
          found_d = 1'b0;
          pos_d   = '0;
        end else begin
          left_d  = left_n;
          right_d = right_n;
          mid_d   = mid_n;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, bounds and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      left_q  <= '0;
      right_q <= '0;
      mid_q   <= '0;
      key_q   <= '0;
      valid_q <= 1'b0;
      found_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      left_q  <= left_d;
      right_q <= right_d;
      mid_q   <= mid_d;
      key_q   <= key_d;
      valid_q <= valid_d;
      found_q <= found_d;
      pos_q   <= pos_d;
    end
  end

  // Key table.
  sbs_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy_o           = (state_q != S_IDLE);
  assign valid_o          = valid_q;
  assign found_o          = found_q;
  assign match_position_o = pos_q;

endmodule

// ===== src/sbs_checker.sv =====
// ----------------------------------------------------------------------------
// sbs_checker
// Port-level checks on the search block, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbs_checker
  import sbs_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input logic             operation_i,
  input logic             valid_o,
  input logic             found_o,
  input logic [POS_W-1:0] match_position_o
);

  // A result is only shown while the block is idle.
  `SBS_ASSERT_NEVER(a_result_while_busy, clk_i, rst_ni, valid_o && busy_o, "result while busy")

  // A failed search reports position zero, a hit reports a nonzero position.
  `SBS_ASSERT(a_miss_pos_zero, clk_i, rst_ni, (valid_o && !found_o) |-> (match_position_o == '0), "miss with nonzero position")
  `SBS_ASSERT(a_hit_pos_nonzero, clk_i, rst_ni, (valid_o && found_o) |-> (match_position_o != '0), "hit at position zero")

  // An accepted search either starts probing or reports at once.
  `SBS_ASSERT(a_search_progress, clk_i, rst_ni, (start_i && !busy_o && (operation_i == OP_SEARCH)) |=> (busy_o || valid_o), "search transfer lost")

  // An accepted write gives no result and leaves the block idle.
  `SBS_ASSERT(a_write_quiet, clk_i, rst_ni, (start_i && !busy_o && (operation_i == OP_WRITE)) |=> (!busy_o && !valid_o), "write transfer gave a result")

endmodule

bind sorted_table_binary_search_top sbs_checker u_sbs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .operation_i      (operation_i),
  .valid_o          (valid_o),
  .found_o          (found_o),
  .match_position_o (match_position_o)
);
